/* src/cis_pkg.sv */
// shared types and constants for the compacted id set unit
// no dependencies; imported by the controller, datapath, top level, checker and testbench top
package cis_pkg;

  localparam int IdentW = 16;
  localparam int CmdW   = 2;
  localparam int CountW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

/* src/compacted_id_set_unit.sv */
// top level of the compacted id set unit: packed list of identifiers
// with add, remove and membership check; uses cis_pkg, cis_ctrl, cis_datapath
//
// usage
//   input channel (in_valid/in_ready): one transaction carries in_cmd
//   (add, remove, check; the unused code acts as check) and in_ident
//   result channel (out_valid/out_ready): one transaction per input
//   transaction with out_was_present, out_entry_count and out_full_drop
//   the accepting edge in the idle state captures the transaction; in the
//   exec state the row of compare cells matches every slot, shifts or
//   appends, and loads the result registers, which drive the result
//   channel from the resp state on
//   one item is in flight at a time: a new item is accepted only after
//   the result transaction of the last one completes
//   a stalled receiver holds the result and keeps in_ready low until the
//   result transaction completes
//   reset clears the controller and the live count; the slot row is not
//   cleared since only slots below the count are ever compared
//   out_entry_count carries the count modulo 32
module compacted_id_set_unit import cis_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CmdW-1:0]   in_cmd,
  input  logic [IdentW-1:0] in_ident,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_was_present,
  output logic [CountW-1:0] out_entry_count,
  output logic              out_full_drop
);

  // command bundle from controller to datapath
  dp_cmd_t dp_cmd;

  cis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  // slot row plus result registers
  cis_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_cmd      (dp_cmd),
    .in_cmd      (in_cmd),
    .in_ident    (in_ident),
    .was_present (out_was_present),
    .entry_count (out_entry_count),
    .full_drop   (out_full_drop)
  );

endmodule

/* src/cis_ctrl.sv */
// controller state machine for the compacted id set unit
// depends on cis_pkg
module cis_ctrl import cis_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/cis_datapath.sv */
// slot row, compare cells and result registers for the compacted id set unit
// depends on cis_pkg
module cis_datapath import cis_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           dp_cmd,
  input  logic [CmdW-1:0]   in_cmd,
  input  logic [IdentW-1:0] in_ident,
  output logic              was_present,
  output logic [CountW-1:0] entry_count,
  output logic              full_drop
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  logic [CmdW-1:0]   op_r;
  logic [IdentW-1:0] ident_r;
  logic [IdentW-1:0] slot_r [CAPACITY];
  logic [CntW-1:0]   count_r, count_nxt;
  logic              was_present_r;
  logic              full_drop_r;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] shift_en;
  logic [CAPACITY-1:0] wr_en;
  logic                present;
  logic                is_add;
  logic                is_remove;
  logic                has_room;
  logic                do_add;
  logic                do_remove;

  // one compare cell per slot, gated by the live count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CntW'(i) < count_r) && (slot_r[i] == ident_r);
    end
  end

  assign present   = |match;
  assign is_add    = (op_r == CMD_ADD);
  assign is_remove = (op_r == CMD_REMOVE);
  assign has_room  = (count_r < CapC);
  assign do_add    = is_add && !present && has_room;
  assign do_remove = is_remove && present;

  // a cell pulls from its upper neighbor when the hit lies at or below it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift_en[i] = do_remove && (i + 1 < CAPACITY) &&
                    (|(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i))));
      wr_en[i]    = do_add && (CntW'(i) == count_r);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_add) begin
      count_nxt = count_r + 1'b1;
    end else if (do_remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op_r    <= in_cmd;
      ident_r <= in_ident;
    end
    if (dp_cmd.exec) begin
      was_present_r <= present;
      full_drop_r   <= is_add && !present && !has_room;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (dp_cmd.exec) begin
        if (wr_en[g]) begin
          slot_r[g] <= ident_r;
        end else if (shift_en[g]) begin
          slot_r[g] <= slot_r[(g + 1) % CAPACITY];
        end
      end
    end
  end

  assign was_present = was_present_r;
  assign entry_count = CountW'(count_r);
  assign full_drop   = full_drop_r;

endmodule

/* tb/sv/cis_checker.sv */
// checker for the compacted id set unit: watches both channels, keeps its
// own copy of the packed identifier list and compares every result
// depends on cis_pkg for widths and command codes
module cis_checker import cis_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CmdW-1:0]   in_cmd,
  input  logic [IdentW-1:0] in_ident,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_was_present,
  input  logic [CountW-1:0] out_entry_count,
  input  logic              out_full_drop,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                drops
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              was_present;
    logic [CountW-1:0] entry_count;
    logic              full_drop;
  } set_reply_t;

  logic [IdentW-1:0] held [CAPACITY];
  int                held_n;
  set_reply_t        reply_q [$];

  // updates the shadow list and returns the reply the unit should give
  function automatic set_reply_t apply_to_set(logic [CmdW-1:0] op, logic [IdentW-1:0] id);
    set_reply_t r;
    int         pos;
    bit         hit;
    pos = -1;
    for (int i = 0; i < held_n; i++) begin
      if (pos < 0 && held[i] == id) pos = i;
    end
    hit = (pos >= 0);
    r.full_drop = 1'b0;
    if (op == CMD_ADD) begin
      if (!hit) begin
        if (held_n < CAPACITY) begin
          held[held_n] = id;
          held_n++;
        end else begin
          r.full_drop = 1'b1;
        end
      end
    end else if (op == CMD_REMOVE && hit) begin
      // close the gap so the list stays packed
      for (int i = pos; i < held_n - 1; i++) held[i] = held[i+1];
      held_n--;
    end
    r.was_present = hit;
    r.entry_count = CountW'(held_n);
    return r;
  endfunction

  always @(posedge clk) begin
    set_reply_t want;
    int         errs;
    if (!rst_n) begin
      held_n = 0;
      reply_q.delete();
      pending <= 0;
    end else begin
      errs = 0;
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result transaction with no outstanding operation");
          errs++;
        end else begin
          want = reply_q.pop_front();
          if (out_was_present !== want.was_present) begin
            $error("was_present: expected %0d, actual %0d", want.was_present, out_was_present);
            errs++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, out_entry_count);
            errs++;
          end
          if (out_full_drop !== want.full_drop) begin
            $error("full_drop: expected %0d, actual %0d", want.full_drop, out_full_drop);
            errs++;
          end
          checked <= checked + 1;
          if (want.full_drop) drops <= drops + 1;
        end
      end
      if (in_valid && in_ready) reply_q.push_back(apply_to_set(in_cmd, in_ident));
      fail_count <= fail_count + errs;
      pending    <= reply_q.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// top of the compacted id set unit testbench: clock, reset, stimulus,
// result-side back pressure and the verdict; uses cis_pkg and cis_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cis_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int BLOCKS     = 13;   // random part: blocks of 100 transactions
  localparam int BLOCK_LEN  = 100;
  localparam int POOL_MAX   = 40;
  // worst case per item is bounded by the random gaps and stalls, so this is many times over
  localparam int LIMIT      = 400000;
  // the unused command code, which the unit treats as a check
  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CmdW-1:0]   in_cmd = CMD_CHECK;
  logic [IdentW-1:0] in_ident = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_was_present;
  logic [CountW-1:0] out_entry_count;
  logic              out_full_drop;

  int fail_count;
  int pending;
  int checked;
  int drops;
  int cycles = 0;

  // per-block idling switches, so some stretches run with no gaps at all
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  compacted_id_set_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_ident        (in_ident),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_was_present (out_was_present),
    .out_entry_count (out_entry_count),
    .out_full_drop   (out_full_drop)
  );

  cis_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_ident        (in_ident),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_was_present (out_was_present),
    .out_entry_count (out_entry_count),
    .out_full_drop   (out_full_drop),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .drops           (drops)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("compacted_id_set_unit regression: fail");
      $finish;
    end
  end

  // result side: random stall before each result while recv_idle is set, ready held until accepted
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one input transaction; entered and left at a rising edge
  // with no gap, valid stays high and only the payload changes
  task automatic send_op(input logic [CmdW-1:0] op, input logic [IdentW-1:0] id);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= op;
    in_ident <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [IdentW-1:0] pool [POOL_MAX];
    int                pool_n;
    int                add_pct;
    int                rem_pct;
    int                pick;
    logic [CmdW-1:0]   op;
    logic [IdentW-1:0] id;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, duplicates, extreme identifiers, fill to capacity
    send_op(CMD_CHECK, 16'h0000);     // lookup on an empty set
    send_op(CMD_REMOVE, 16'hffff);    // remove when absent, empty set
    send_op(CMD_ADD, 16'h0000);
    send_op(CMD_ADD, 16'h0000);       // add when already present
    send_op(CMD_ADD, 16'hffff);
    send_op(CMD_SPARE, 16'hffff);     // unused code acts as a lookup
    for (int k = 1; k <= CAPACITY - 2; k++) send_op(CMD_ADD, IdentW'(k));
    send_op(CMD_ADD, 16'h8000);       // absent identifier on a full set: dropped
    send_op(CMD_ADD, 16'h0000);       // present on a full set: no drop
    send_op(CMD_REMOVE, 16'h0007);    // middle entry, later ones shift down
    send_op(CMD_REMOVE, 16'h0000);    // first slot
    send_op(CMD_REMOVE, IdentW'(CAPACITY - 2)); // last live slot
    send_op(CMD_CHECK, 16'h0007);
    send_op(CMD_ADD, 16'h8000);       // now there is room again
    send_op(CMD_SPARE, 16'h0000);

    // pause the sender until the unit has answered everything
    drain_results();

    // random part: each block gets its own identifier pool, command mix
    // and idling pattern; small pools give many hits, large ones fill the set
    for (int blk = 0; blk < BLOCKS; blk++) begin
      pick = $urandom_range(0, 3);
      send_idle = pick[0];
      recv_idle = pick[1];
      pool_n = $urandom_range(4, POOL_MAX);
      for (int k = 0; k < pool_n; k++) pool[k] = IdentW'($urandom_range(0, 65535));
      if ($urandom_range(0, 1)) pool[0] = '0;
      if ($urandom_range(0, 1)) pool[pool_n-1] = '1;
      case ($urandom_range(0, 2))
        0: begin
          add_pct = 65;   // fill-heavy, reaches full and drops
          rem_pct = 15;
        end
        1: begin
          add_pct = 20;   // drain-heavy, empties the set
          rem_pct = 60;
        end
        default: begin
          add_pct = 40;
          rem_pct = 40;
        end
      endcase
      for (int n = 0; n < BLOCK_LEN; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          // noise: any command code with any identifier
          op = CmdW'($urandom_range(0, 3));
          id = IdentW'($urandom_range(0, 65535));
        end else begin
          id   = pool[$urandom_range(0, pool_n - 1)];
          pick = $urandom_range(0, 99);
          if (pick < add_pct) op = CMD_ADD;
          else if (pick < add_pct + rem_pct) op = CMD_REMOVE;
          else if (pick % 2) op = CMD_CHECK;
          else op = CMD_SPARE;
        end
        send_op(op, id);
      end
      if ($urandom_range(0, 2) == 0) drain_results();
    end

    // wait out the last results, then let the clock run on for anything stray
    send_idle = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d checked operations, %0d of them adds dropped on a full set",
             checked, drops);
    if (fail_count == 0 && pending == 0) begin
      $display("compacted_id_set_unit regression: pass");
    end else begin
      $display("compacted_id_set_unit regression: fail");
    end
    $finish;
  end

endmodule
